### hdl/qprm_pkg.sv
// package: shared types, constants and arithmetic helpers for the quaternion unit
`timescale 1ns / 1ps
package qprm_pkg;

    typedef logic signed [31:0] q_t;
    typedef logic signed [63:0] prod_t;
    typedef logic signed [47:0] rnd_t;
    typedef logic signed [51:0] acc_t;

    typedef enum logic [1:0] {
        KIND_PRODUCT = 2'd0,
        KIND_ROTATE  = 2'd1,
        KIND_MATRIX  = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    localparam q_t   Q_ONE   = 32'sd65536;
    localparam q_t   Q_MAX   = 32'sh7fffffff;
    localparam q_t   Q_MIN   = 32'sh80000000;
    localparam acc_t ACC_ONE = 52'sd65536;
    localparam acc_t ACC_MAX = 52'sh0_0000_7fff_ffff;
    localparam acc_t ACC_MIN = -52'sh0_0000_8000_0000;

    function automatic rnd_t qround(input prod_t p);
        prod_t q;
        q = p + 64'sd32768;
        return q[63:16];
    endfunction

    function automatic acc_t wext(input rnd_t r);
        return {{4{r[47]}}, r};
    endfunction

    function automatic q_t sat(input acc_t v);
        q_t s;
        if (v > ACC_MAX)
            s = Q_MAX;
        else if (v < ACC_MIN)
            s = Q_MIN;
        else
            s = v[31:0];
        return s;
    endfunction

    function automatic q_t qneg(input q_t v);
        return (v == Q_MIN) ? Q_MAX : -v;
    endfunction

    // a + b + c - d
    function automatic q_t sum_ppm(input rnd_t a, input rnd_t b, input rnd_t c, input rnd_t d);
        return sat(wext(a) + wext(b) + wext(c) - wext(d));
    endfunction

    // a - b - c - d
    function automatic q_t sum_pmm(input rnd_t a, input rnd_t b, input rnd_t c, input rnd_t d);
        return sat(wext(a) - wext(b) - wext(c) - wext(d));
    endfunction

endpackage

### hdl/quaternion_product_rotate_matrix_unit.sv
// top level: pipelined quaternion product, vector rotation and rotation matrix
`timescale 1ns / 1ps
// Takes one word per cycle while in_stall is low. Product and rotate give
// one word each; matrix gives four row words and holds in_stall high while
// the output register steps through rows. Both Hamilton products run on one
// 16-multiplier bank each (stages 2 and 5), each followed by a rounding stage
// and a sum/saturate stage; the whole pipe advances together whenever the
// output register is empty or hands off its last word.
module quaternion_product_rotate_matrix_unit
    import qprm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic signed [31:0] a_w,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_w,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] res_0,
    output logic signed [31:0] res_1,
    output logic signed [31:0] res_2,
    output logic signed [31:0] res_3,
    output logic [1:0]  row_index,
    output logic        last
);

    logic en;
    logic out_done;

    logic [6:1] v_reg;

    kind_t k1_reg, k2_reg, k3_reg, k4_reg, k5_reg, k6_reg;
    q_t    p1_reg [4];
    q_t    q1_reg [4];
    q_t    c1_reg [4];
    q_t    c2_reg [4];
    q_t    c3_reg [4];
    q_t    c4_reg [4];
    prod_t m2_reg [16];
    rnd_t  r3_reg [16];
    q_t    h4_reg [4];
    q_t    h5_reg [4];
    q_t    h6_reg [4];
    q_t    x4_reg [9];
    q_t    x5_reg [9];
    q_t    x6_reg [9];
    prod_t m5_reg [16];
    rnd_t  r6_reg [16];

    q_t    h1_next [4];
    q_t    x_next  [9];
    q_t    h2_next [4];

    logic  out_valid_reg;
    kind_t out_kind_reg;
    logic [1:0] row_reg;
    q_t    out_q_reg [4];
    q_t    out_m_reg [9];
    q_t    out_q_next [4];

    assign out_done = (out_kind_reg != KIND_MATRIX) || (row_reg == 2'd3);
    assign en       = !out_valid_reg || (!out_stall && out_done);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[5:1], in_valid};
        end
    end

    // stage 1: operand select
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_reg    <= kind_t'(kind);
            p1_reg[0] <= a_w;
            p1_reg[1] <= a_x;
            p1_reg[2] <= a_y;
            p1_reg[3] <= a_z;
            unique case (kind_t'(kind))
                KIND_PRODUCT:
                begin
                    q1_reg[0] <= b_w;
                    q1_reg[1] <= b_x;
                    q1_reg[2] <= b_y;
                    q1_reg[3] <= b_z;
                end
                KIND_ROTATE:
                begin
                    q1_reg[0] <= '0;
                    q1_reg[1] <= b_x;
                    q1_reg[2] <= b_y;
                    q1_reg[3] <= b_z;
                end
                KIND_MATRIX, KIND_NONE:
                begin
                    q1_reg[0] <= a_w;
                    q1_reg[1] <= a_x;
                    q1_reg[2] <= a_y;
                    q1_reg[3] <= a_z;
                end
            endcase
            c1_reg[0] <= a_w;
            c1_reg[1] <= qneg(a_x);
            c1_reg[2] <= qneg(a_y);
            c1_reg[3] <= qneg(a_z);
        end
    end

    // stages 2 and 3: first product bank and rounding
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k2_reg <= k1_reg;
            k3_reg <= k2_reg;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    m2_reg[i*4+j] <= 64'(p1_reg[i]) * 64'(q1_reg[j]);
                end
            end
            for (int n = 0; n < 16; n++)
            begin
                r3_reg[n] <= qround(m2_reg[n]);
            end
        end
    end

    // stage 4: first hamilton sums and matrix entries
    always_comb
    begin
        h1_next[0] = sum_pmm(r3_reg[0], r3_reg[5], r3_reg[10], r3_reg[15]);
        h1_next[1] = sum_ppm(r3_reg[1], r3_reg[4], r3_reg[11], r3_reg[14]);
        h1_next[2] = sum_ppm(r3_reg[2], r3_reg[8], r3_reg[13], r3_reg[7]);
        h1_next[3] = sum_ppm(r3_reg[3], r3_reg[12], r3_reg[6], r3_reg[9]);
        x_next[0] = sat(ACC_ONE - 2 * wext(r3_reg[10]) - 2 * wext(r3_reg[15]));
        x_next[1] = sat(2 * wext(r3_reg[6]) - 2 * wext(r3_reg[3]));
        x_next[2] = sat(2 * wext(r3_reg[7]) + 2 * wext(r3_reg[2]));
        x_next[3] = sat(2 * wext(r3_reg[6]) + 2 * wext(r3_reg[3]));
        x_next[4] = sat(ACC_ONE - 2 * wext(r3_reg[5]) - 2 * wext(r3_reg[15]));
        x_next[5] = sat(2 * wext(r3_reg[11]) - 2 * wext(r3_reg[1]));
        x_next[6] = sat(2 * wext(r3_reg[7]) - 2 * wext(r3_reg[2]));
        x_next[7] = sat(2 * wext(r3_reg[11]) + 2 * wext(r3_reg[1]));
        x_next[8] = sat(ACC_ONE - 2 * wext(r3_reg[5]) - 2 * wext(r3_reg[10]));
    end

    // stages 4 to 6: second product bank with conj(a) and rounding
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k4_reg <= k3_reg;
            k5_reg <= k4_reg;
            k6_reg <= k5_reg;
            c4_reg <= c3_reg;
            h4_reg <= h1_next;
            h5_reg <= h4_reg;
            h6_reg <= h5_reg;
            x4_reg <= x_next;
            x5_reg <= x4_reg;
            x6_reg <= x5_reg;
            for (int i = 0; i < 4; i++)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    m5_reg[i*4+j] <= 64'(h4_reg[i]) * 64'(c4_reg[j]);
                end
            end
            for (int n = 0; n < 16; n++)
            begin
                r6_reg[n] <= qround(m5_reg[n]);
            end
        end
    end

    always_comb
    begin
        h2_next[0] = sum_pmm(r6_reg[0], r6_reg[5], r6_reg[10], r6_reg[15]);
        h2_next[1] = sum_ppm(r6_reg[1], r6_reg[4], r6_reg[11], r6_reg[14]);
        h2_next[2] = sum_ppm(r6_reg[2], r6_reg[8], r6_reg[13], r6_reg[7]);
        h2_next[3] = sum_ppm(r6_reg[3], r6_reg[12], r6_reg[6], r6_reg[9]);
        unique case (k6_reg)
            KIND_PRODUCT:
            begin
                out_q_next = '{h6_reg[1], h6_reg[2], h6_reg[3], h6_reg[0]};
            end
            KIND_ROTATE:
            begin
                out_q_next = '{h2_next[1], h2_next[2], h2_next[3], h2_next[0]};
            end
            KIND_MATRIX, KIND_NONE:
            begin
                out_q_next = '{'0, '0, '0, '0};
            end
        endcase
    end

    // output register, steps through matrix rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
            out_kind_reg  <= KIND_PRODUCT;
        end
        else if (en)
        begin
            out_valid_reg <= v_reg[6];
            row_reg       <= '0;
            out_kind_reg  <= k6_reg;
        end
        else if (!out_stall)
        begin
            row_reg <= row_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_q_reg <= out_q_next;
            out_m_reg <= x6_reg;
        end
    end

    always_comb
    begin
        res_0 = out_q_reg[0];
        res_1 = out_q_reg[1];
        res_2 = out_q_reg[2];
        res_3 = out_q_reg[3];
        if (out_kind_reg == KIND_MATRIX)
        begin
            unique case (row_reg)
                2'd0:
                begin
                    res_0 = out_m_reg[0];
                    res_1 = out_m_reg[1];
                    res_2 = out_m_reg[2];
                    res_3 = '0;
                end
                2'd1:
                begin
                    res_0 = out_m_reg[3];
                    res_1 = out_m_reg[4];
                    res_2 = out_m_reg[5];
                    res_3 = '0;
                end
                2'd2:
                begin
                    res_0 = out_m_reg[6];
                    res_1 = out_m_reg[7];
                    res_2 = out_m_reg[8];
                    res_3 = '0;
                end
                2'd3:
                begin
                    res_0 = '0;
                    res_1 = '0;
                    res_2 = '0;
                    res_3 = Q_ONE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign row_index = row_reg;
    assign last      = out_done;

    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=>
        (out_valid && row_index == $past(row_index) + 2'd1))
        else $error("matrix row did not advance");

    a_row_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (row_index != 2'd0) |-> out_valid)
        else $error("row counter running without a word");

    a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (row_index != 2'd3 && in_stall))
        else $error("inner matrix row does not hold input");

endmodule

### dv/tb.sv
// testbench: random and directed checking of the quaternion product, rotate and matrix unit
`timescale 1ns / 1ps
module tb;
    import qprm_pkg::*;

    typedef struct packed {
        kind_t k;
        q_t aw, ax, ay, az, bw, bx, by, bz;
    } quat_op_t;

    typedef struct packed {
        q_t r0, r1, r2, r3;
        logic [1:0] row;
        logic lst;
    } quat_res_t;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [1:0] kind;
    logic signed [31:0] a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z;
    logic signed [31:0] res_0, res_1, res_2, res_3;
    logic [1:0] row_index;
    logic last;

    quat_op_t pending_ops[$];
    quat_res_t expected_words[$];
    int errors = 0;
    int words_seen = 0;
    int ops_sent = 0;
    bit hold_off = 0;
    int burst_left = 0, gap_left = 0;
    int stall_phase = 0;

    quaternion_product_rotate_matrix_unit DUT (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint qmul(longint x, longint y);
        longint p;
        p = x * y + 32768;
        return p >>> 16;
    endfunction

    function automatic longint sat64(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // order w, x, y, z
    function automatic void hamilton_mul(input longint p[4], input longint q[4],
                                         output longint r[4]);
        r[0] = sat64(qmul(p[0], q[0]) - qmul(p[1], q[1]) - qmul(p[2], q[2])
                     - qmul(p[3], q[3]));
        r[1] = sat64(qmul(p[0], q[1]) + qmul(p[1], q[0]) + qmul(p[2], q[3])
                     - qmul(p[3], q[2]));
        r[2] = sat64(qmul(p[0], q[2]) + qmul(p[2], q[0]) + qmul(p[3], q[1])
                     - qmul(p[1], q[3]));
        r[3] = sat64(qmul(p[0], q[3]) + qmul(p[3], q[0]) + qmul(p[1], q[2])
                     - qmul(p[2], q[1]));
    endfunction

    function automatic quat_res_t mk(longint c0, longint c1, longint c2, longint c3,
                                     int row, bit lst);
        quat_res_t r;
        r.r0 = sat64(c0);
        r.r1 = sat64(c1);
        r.r2 = sat64(c2);
        r.r3 = sat64(c3);
        r.row = row[1:0];
        r.lst = lst;
        return r;
    endfunction

    task automatic predict_quat(input quat_op_t op);
        longint a[4], b[4], v[4], t[4], c[4], r[4];
        longint w, x, y, z, xx, yy, zz, xy, xz, yz, wx, wy, wz;
        a = '{longint'(op.aw), longint'(op.ax), longint'(op.ay), longint'(op.az)};
        b = '{longint'(op.bw), longint'(op.bx), longint'(op.by), longint'(op.bz)};
        case (op.k)
            KIND_PRODUCT:
            begin
                hamilton_mul(a, b, r);
                expected_words.push_back(mk(r[1], r[2], r[3], r[0], 0, 1));
            end
            KIND_ROTATE:
            begin
                v = '{0, b[1], b[2], b[3]};
                hamilton_mul(a, v, t);
                c[0] = a[0];
                for (int i = 1; i < 4; i++)
                    c[i] = sat64(-a[i]);
                hamilton_mul(t, c, r);
                expected_words.push_back(mk(r[1], r[2], r[3], r[0], 0, 1));
            end
            KIND_MATRIX:
            begin
                w = a[0]; x = a[1]; y = a[2]; z = a[3];
                xx = 2 * qmul(x, x); yy = 2 * qmul(y, y); zz = 2 * qmul(z, z);
                xy = 2 * qmul(x, y); xz = 2 * qmul(x, z); yz = 2 * qmul(y, z);
                wx = 2 * qmul(w, x); wy = 2 * qmul(w, y); wz = 2 * qmul(w, z);
                expected_words.push_back(mk(65536 - yy - zz, xy - wz, xz + wy, 0, 0, 0));
                expected_words.push_back(mk(xy + wz, 65536 - xx - zz, yz - wx, 0, 1, 0));
                expected_words.push_back(mk(xz - wy, yz + wx, 65536 - xx - yy, 0, 2, 0));
                expected_words.push_back(mk(0, 0, 0, 65536, 3, 1));
            end
            default:
                expected_words.push_back(mk(0, 0, 0, 0, 0, 1));
        endcase
    endtask

    function automatic q_t rand_q(int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 131072)) - 65536;
            2: return $signed($urandom_range(0, 16777216)) - 8388608;
            default:
                case ($urandom_range(0, 4))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return Q_ONE;
                    3: return -Q_ONE;
                    default: return '0;
                endcase
        endcase
    endfunction

    function automatic quat_op_t rand_op();
        quat_op_t op;
        int m;
        m = $urandom_range(0, 9);
        m = (m < 3) ? 0 : (m < 6) ? 1 : (m < 8) ? 2 : 3;
        op.k = kind_t'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2));
        op.aw = rand_q(m); op.ax = rand_q(m); op.ay = rand_q(m); op.az = rand_q(m);
        op.bw = rand_q(m); op.bx = rand_q(m); op.by = rand_q(m); op.bz = rand_q(m);
        return op;
    endfunction

    function automatic quat_op_t same_op(kind_t k, q_t v, q_t u);
        quat_op_t op;
        op.k = k;
        op.aw = v; op.ax = v; op.ay = v; op.az = v;
        op.bw = u; op.bx = u; op.by = u; op.bz = u;
        return op;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            {kind, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z} <= '0;
        end
        else
        begin
            automatic bit done_word = in_valid && !in_stall;
            automatic bit busy = in_valid && !done_word;
            if (done_word)
            begin
                predict_quat(pending_ops.pop_front());
                ops_sent++;
            end
            if (!busy)
            begin
                if (gap_left > 0 && burst_left == 0)
                    gap_left--;
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (pending_ops.size() > 0 && !hold_off && (gap_left == 0 || burst_left > 0)
                    && (burst_left > 0))
                begin
                    quat_op_t op;
                    op = pending_ops[0];
                    burst_left--;
                    in_valid <= 1'b1;
                    kind <= op.k;
                    a_w <= op.aw; a_x <= op.ax; a_y <= op.ay; a_z <= op.az;
                    b_w <= op.bw; b_x <= op.bx; b_y <= op.by; b_z <= op.bz;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern and monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                quat_res_t e;
                words_seen++;
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word res_0=%0d", res_0);
                    errors++;
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (res_0 !== e.r0)
                    begin
                        $error("res_0 expected %0d actual %0d", e.r0, res_0); errors++;
                    end
                    if (res_1 !== e.r1)
                    begin
                        $error("res_1 expected %0d actual %0d", e.r1, res_1); errors++;
                    end
                    if (res_2 !== e.r2)
                    begin
                        $error("res_2 expected %0d actual %0d", e.r2, res_2); errors++;
                    end
                    if (res_3 !== e.r3)
                    begin
                        $error("res_3 expected %0d actual %0d", e.r3, res_3); errors++;
                    end
                    if (row_index !== e.row)
                    begin
                        $error("row_index expected %0d actual %0d", e.row, row_index);
                        errors++;
                    end
                    if (last !== e.lst)
                    begin
                        $error("last expected %0d actual %0d", e.lst, last); errors++;
                    end
                end
            end
            stall_phase = (stall_phase + 1) % 200;
            if (stall_phase < 60)
                out_stall <= 1'b0;
            else if (stall_phase < 120)
                out_stall <= ($urandom_range(0, 3) == 0);
            else
                out_stall <= ($urandom_range(0, 1) == 0);
        end
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        kind_t ks[3];
        ks = '{KIND_PRODUCT, KIND_ROTATE, KIND_MATRIX};
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        {kind, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z} = '0;
        foreach (ks[i])
        begin
            pending_ops.push_back(same_op(ks[i], Q_MAX, Q_MAX));
            pending_ops.push_back(same_op(ks[i], Q_MIN, Q_MIN));
            pending_ops.push_back(same_op(ks[i], Q_MIN, Q_MAX));
            pending_ops.push_back(same_op(ks[i], Q_ONE, -Q_ONE));
            pending_ops.push_back(same_op(ks[i], 0, 32'sh0000_8000));
            pending_ops.push_back(same_op(ks[i], -32'sd1, 32'sh5555_aaaa));
        end
        pending_ops.push_back(same_op(KIND_NONE, Q_MAX, Q_MIN));
        pending_ops.push_back(same_op(KIND_NONE, 32'sh2aaa_5555, -32'sd1));
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_ops.size() == 0);
        hold_off = 1;
        wait (expected_words.size() == 0 && !in_valid);
        hold_off = 0;
        for (int i = 0; i < 160; i++)
            pending_ops.push_back(rand_op());
        wait (pending_ops.size() == 0);
        wait (expected_words.size() == 0);
        repeat (40) @(posedge clk);
        $display("ran %0d operation words through product, rotate, matrix and unused kind",
                 ops_sent);
        $display("checked %0d result words under random input gaps and output stalls",
                 words_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
